@@ sv/signed_integer_to_radix_text_assert.svh @@
// Assertion macros shared by the conversion block.
// Each use expects clk and rst in scope.
`ifndef SIGNED_INTEGER_TO_RADIX_TEXT_ASSERT_SVH
`define SIGNED_INTEGER_TO_RADIX_TEXT_ASSERT_SVH

// Condition holds at every edge outside reset.
`define SIRT_ASSERT_HOLD(name, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("sirt: invariant violated");

// Consequent holds in the same cycle as the antecedent.
`define SIRT_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sirt: implication violated");

`endif

@@ sv/sirt_pkg.sv @@
package sirt_pkg;

  // Default sizing of the block
  localparam int MAX_RADIX_DEF  = 16;
  localparam int VALUE_BITS_DEF = 32;

  // Fixed field widths
  localparam int NUMBER_W = 32;
  localparam int RADIX_W  = 5;
  localparam int ALPHA_W  = 64;
  localparam int CHAR_W   = 8;

  // Quotient bits produced by the divider per cycle
  localparam int DIV_STEP_BITS = 8;

  // Characters with a special meaning
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // Register indexes of the configuration port
  typedef enum logic [1:0] {
    REG_RADIX      = 2'd0,
    REG_ALPHA_LOW  = 2'd1,
    REG_ALPHA_HIGH = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [RADIX_W-1:0] radix;
    logic [ALPHA_W-1:0] alphabet_low;
    logic [ALPHA_W-1:0] alphabet_high;
  } cfg_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } out_item_t;

  // Character of the alphabet for digit value d
  function automatic logic [CHAR_W-1:0] alpha_char(input cfg_t c, input logic [3:0] d);
    logic [2*ALPHA_W-1:0] all;
    all = {c.alphabet_high, c.alphabet_low};
    return all[{d, 3'b000} +: CHAR_W];
  endfunction

endpackage

@@ sv/sirt_fifo.sv @@
module sirt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic             wr;
  logic             rd;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign wr    = push && !full;
  assign rd    = pop && !empty;
  assign rdata = mem[rptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == PTR_W'(DEPTH-1)) ? '0 : wptr + PTR_W'(1);
      end
      if (rd) begin
        rptr <= (rptr == PTR_W'(DEPTH-1)) ? '0 : rptr + PTR_W'(1);
      end
      if (wr && !rd) begin
        count <= count + CNT_W'(1);
      end else if (rd && !wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

@@ sv/sirt_front.sv @@
module sirt_front #(
  parameter int VALUE_BITS = 32
) (
  input  logic signed [sirt_pkg::NUMBER_W-1:0] number,
  output logic        [VALUE_BITS:0]           item
);

  import sirt_pkg::*;

  logic signed [VALUE_BITS-1:0] value;
  logic        [VALUE_BITS-1:0] raw;
  logic                         neg;
  logic        [VALUE_BITS-1:0] mag;

  // Sign-extend or truncate to the working width
  assign value = VALUE_BITS'(number);
  assign raw   = value;
  assign neg   = raw[VALUE_BITS-1];

  // Take the magnitude; the most negative value maps to 2^(VALUE_BITS-1)
  assign mag  = neg ? (~raw + VALUE_BITS'(1)) : raw;
  assign item = {neg, mag};

endmodule

@@ sv/sirt_back.sv @@
module sirt_back #(
  parameter int MAX_RADIX  = 16,
  parameter int VALUE_BITS = 32,
  parameter int OQ_DEPTH   = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  sirt_pkg::cfg_t                   cfg,
  input  logic                             iq_empty,
  input  logic [VALUE_BITS:0]              iq_item,
  output logic                             iq_pop,
  input  logic [$clog2(OQ_DEPTH+1)-1:0]    oq_count,
  output logic                             oq_push,
  output sirt_pkg::out_item_t              oq_item
);

  import sirt_pkg::*;

  localparam int ROUNDS   = (VALUE_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int PAD_BITS = ROUNDS * DIV_STEP_BITS;
  localparam int RND_W    = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam int IDX_W    = $clog2(VALUE_BITS);
  localparam int CNT_W    = $clog2(VALUE_BITS + 1);
  localparam int OQC_W    = $clog2(OQ_DEPTH + 1);

  typedef enum logic [1:0] {
    IDLE,
    DIVIDE,
    SIGN,
    EMIT
  } state_t;

  state_t              state;
  logic [PAD_BITS-1:0] work;
  logic [3:0]          rem;
  logic [RND_W-1:0]    round;
  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    cnt_next;
  logic                neg;
  logic                alpha_ok;
  logic                ok_next;
  logic [IDX_W-1:0]    rd_idx;
  logic                rd_pend;
  logic                rd_last;
  logic [3:0]          rd_data;
  logic                issue;
  logic                sign_push;
  logic [PAD_BITS-1:0] work_next;
  logic [3:0]          rem_next;
  logic [3:0]          digit_store [VALUE_BITS];

  // Check the alphabet: radix in range, no sign characters, no repeats
  always_comb begin
    logic [CHAR_W-1:0] c;
    ok_next = (cfg.radix >= RADIX_W'(2)) && (cfg.radix <= RADIX_W'(MAX_RADIX));
    for (int i = 0; i < 16; i++) begin
      c = alpha_char(cfg, 4'(i));
      if (RADIX_W'(i) < cfg.radix) begin
        if (c == CHAR_PLUS || c == CHAR_MINUS) begin
          ok_next = 1'b0;
        end
        for (int j = i + 1; j < 16; j++) begin
          if (RADIX_W'(j) < cfg.radix && alpha_char(cfg, 4'(j)) == c) begin
            ok_next = 1'b0;
          end
        end
      end
    end
  end

  // Restoring division by the radix, DIV_STEP_BITS quotient bits per cycle
  always_comb begin
    logic [PAD_BITS-1:0] w;
    logic [RADIX_W-1:0]  t;
    logic [3:0]          r;
    w = work;
    r = rem;
    for (int k = 0; k < DIV_STEP_BITS; k++) begin
      t = {r, w[PAD_BITS-1]};
      w = {w[PAD_BITS-2:0], 1'b0};
      if (t >= cfg.radix) begin
        t = t - cfg.radix;
        w[0] = 1'b1;
      end
      r = t[3:0];
    end
    work_next = w;
    rem_next  = r;
  end

  assign cnt_next = cnt + CNT_W'(1);

  // Handshakes toward both queues
  assign iq_pop    = (state == IDLE) && !iq_empty;
  assign sign_push = (state == SIGN) && (oq_count < OQC_W'(OQ_DEPTH));
  assign issue     = (state == EMIT) &&
                     ((OQC_W+1)'(oq_count) + (OQC_W+1)'(rd_pend) < (OQC_W+1)'(OQ_DEPTH));
  assign oq_push   = rd_pend || sign_push;

  always_comb begin
    if (rd_pend) begin
      oq_item.ch   = alpha_char(cfg, rd_data);
      oq_item.last = rd_last;
    end else begin
      oq_item.ch   = CHAR_MINUS;
      oq_item.last = 1'b0;
    end
  end

  // Sequence one number: divide out digits, then emit sign and digits
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      work     <= '0;
      rem      <= '0;
      round    <= '0;
      cnt      <= '0;
      neg      <= 1'b0;
      alpha_ok <= 1'b0;
      rd_pend  <= 1'b0;
      rd_idx   <= '0;
      rd_last  <= 1'b0;
    end else begin
      alpha_ok <= ok_next;
      rd_pend  <= issue;
      case (state)
        IDLE: begin
          // Drop the transaction when the alphabet is invalid
          if (!iq_empty && alpha_ok) begin
            work  <= PAD_BITS'(iq_item[VALUE_BITS-1:0]);
            neg   <= iq_item[VALUE_BITS];
            rem   <= '0;
            round <= '0;
            cnt   <= '0;
            state <= DIVIDE;
          end
        end
        DIVIDE: begin
          work <= work_next;
          if (round == RND_W'(ROUNDS - 1)) begin
            round  <= '0;
            rem    <= '0;
            cnt    <= cnt_next;
            rd_idx <= cnt[IDX_W-1:0];
            if (work_next == '0 || cnt_next == CNT_W'(VALUE_BITS)) begin
              state <= neg ? SIGN : EMIT;
            end
          end else begin
            rem   <= rem_next;
            round <= round + RND_W'(1);
          end
        end
        SIGN: begin
          if (sign_push) begin
            state <= EMIT;
          end
        end
        EMIT: begin
          if (issue) begin
            rd_last <= (rd_idx == '0);
            rd_idx  <= rd_idx - IDX_W'(1);
            if (rd_idx == '0) begin
              state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // Digit store: write on each finished digit, read most significant first
  always_ff @(posedge clk) begin
    if (state == DIVIDE && round == RND_W'(ROUNDS - 1)) begin
      digit_store[cnt[IDX_W-1:0]] <= rem_next;
    end
    if (issue) begin
      rd_data <= digit_store[rd_idx];
    end
  end

endmodule

@@ sv/signed_integer_to_radix_text.sv @@
// Converts a signed 32-bit number to text in a configured radix (2 to 16), most
// significant digit first, each digit drawn from a configured alphabet; a negative
// number gets a leading '-', and the final character of each number carries last.
// An alphabet shorter than two or longer than 16, holding '+' or '-', or repeating
// a character yields no characters for the number. The most negative number converts
// as its unsigned magnitude. Timing: a divider produces eight quotient bits per
// cycle, and characters leave through the digit store read port at one per cycle
// while the result queue has room. A two-entry input queue takes new numbers while
// one converts, and a four-entry result queue absorbs stalls on the output side.
// Configuration is written through cfg_valid/cfg_ready (always ready); the user must
// write it only while the block is idle, and the block itself does not enforce this.
`include "signed_integer_to_radix_text_assert.svh"

module signed_integer_to_radix_text #(
  parameter int MAX_RADIX  = sirt_pkg::MAX_RADIX_DEF,
  parameter int VALUE_BITS = sirt_pkg::VALUE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  input  logic signed [sirt_pkg::NUMBER_W-1:0] number,
  output logic                                 full,
  output logic                                 empty,
  input  logic                                 pop,
  output logic        [sirt_pkg::CHAR_W-1:0]   out_char,
  output logic                                 last,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [1:0]                    cfg_index,
  input  logic        [sirt_pkg::ALPHA_W-1:0]  cfg_data
);

  import sirt_pkg::*;

  localparam int IQ_DEPTH = 2;
  localparam int OQ_DEPTH = 4;
  localparam int IQC_W    = $clog2(IQ_DEPTH + 1);
  localparam int OQC_W    = $clog2(OQ_DEPTH + 1);

  cfg_t              cfg;
  logic [VALUE_BITS:0] front_item;
  logic [VALUE_BITS:0] iq_item;
  logic              iq_empty;
  logic              iq_pop;
  logic [IQC_W-1:0]  iq_count;
  logic              oq_push;
  out_item_t         oq_item;
  out_item_t         oq_head;
  logic              oq_full;
  logic [OQC_W-1:0]  oq_count;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_RADIX:      cfg.radix         <= cfg_data[RADIX_W-1:0];
        REG_ALPHA_LOW:  cfg.alphabet_low  <= cfg_data;
        REG_ALPHA_HIGH: cfg.alphabet_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: take the sign apart from the magnitude
  sirt_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .number(number),
    .item  (front_item)
  );

  sirt_fifo #(
    .WIDTH(VALUE_BITS + 1),
    .DEPTH(IQ_DEPTH)
  ) u_in_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(front_item),
    .full (full),
    .pop  (iq_pop),
    .rdata(iq_item),
    .empty(iq_empty),
    .count(iq_count)
  );

  // Back: divide out digits and emit characters
  sirt_back #(
    .MAX_RADIX (MAX_RADIX),
    .VALUE_BITS(VALUE_BITS),
    .OQ_DEPTH  (OQ_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .iq_empty(iq_empty),
    .iq_item (iq_item),
    .iq_pop  (iq_pop),
    .oq_count(oq_count),
    .oq_push (oq_push),
    .oq_item (oq_item)
  );

  sirt_fifo #(
    .WIDTH($bits(out_item_t)),
    .DEPTH(OQ_DEPTH)
  ) u_out_queue (
    .clk  (clk),
    .rst  (rst),
    .push (oq_push),
    .wdata(oq_item),
    .full (oq_full),
    .pop  (pop),
    .rdata(oq_head),
    .empty(empty),
    .count(oq_count)
  );

  assign out_char = oq_head.ch;
  assign last     = oq_head.last;

  // The back never writes a character that the result queue cannot hold
  `SIRT_ASSERT_IMPL(a_oq_no_overflow, oq_push, !oq_full)
  // Occupancy stays within the queue depths
  `SIRT_ASSERT_HOLD(a_oq_bound, oq_count <= OQC_W'(OQ_DEPTH))
  `SIRT_ASSERT_HOLD(a_iq_bound, iq_count <= IQC_W'(IQ_DEPTH))
  // A popped number leaves the input queue only when one is present
  `SIRT_ASSERT_IMPL(a_iq_pop_nonempty, iq_pop, iq_count != '0)

endmodule

@@ tb/signed_integer_to_radix_text_tb.sv @@
`timescale 1ns / 1ps

module signed_integer_to_radix_text_tb;
  import sirt_pkg::*;

  localparam int LONG_HOLD    = 400;
  localparam int QUIET_CYCLES = 600;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int TARGET_ITEMS = 410;

  // Tracks the configured alphabet and the characters each number should produce
  class radix_text_scoreboard;
    logic [RADIX_W-1:0]  base;
    logic [ALPHA_W-1:0]  glyphs_lo;
    logic [ALPHA_W-1:0]  glyphs_hi;
    logic [NUMBER_W-1:0] mag_seen;
    logic [3:0]          digit_lane [NUMBER_W];
    logic [5:0]          digits_used;
    logic                was_negative;
    out_item_t           pending_chars[$];
    int                  mismatches;

    function new();
      base         = '0;
      glyphs_lo    = '0;
      glyphs_hi    = '0;
      mag_seen     = '0;
      digits_used  = '0;
      was_negative = 1'b0;
      mismatches   = 0;
    endfunction

    function void note_write(cfg_reg_t idx, logic [ALPHA_W-1:0] data);
      case (idx)
        REG_RADIX:      base = data[RADIX_W-1:0];
        REG_ALPHA_LOW:  glyphs_lo = data;
        REG_ALPHA_HIGH: glyphs_hi = data;
        default: ;
      endcase
    endfunction

    function logic [CHAR_W-1:0] glyph(logic [3:0] d);
      if (d[3]) return glyphs_hi[d[2:0]*8 +: 8];
      return glyphs_lo[d[2:0]*8 +: 8];
    endfunction

    // Reject short, oversized, signed or repeating alphabets
    function bit alphabet_usable();
      logic [CHAR_W-1:0] c;
      if (base < 2 || base > MAX_RADIX_DEF) return 1'b0;
      for (int i = 0; i < base; i++) begin
        c = glyph(i[3:0]);
        if (c == CHAR_PLUS || c == CHAR_MINUS) return 1'b0;
        for (int j = i + 1; j < base; j++) begin
          if (glyph(j[3:0]) == c) return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    // Queue the characters of one accepted number; return how many
    function int note_number(logic [NUMBER_W-1:0] n);
      logic [NUMBER_W-1:0] rest;
      int                  cnt;
      out_item_t           item;
      if (!alphabet_usable()) return 0;
      was_negative = n[NUMBER_W-1];
      rest = was_negative ? ~n + 1'b1 : n;
      mag_seen = rest;
      cnt = 0;
      do begin
        digit_lane[cnt] = 4'(rest % base);
        cnt++;
        rest = rest / base;
      end while (rest != 0 && cnt < NUMBER_W);
      digits_used = 6'(cnt);
      if (was_negative) begin
        item.ch   = CHAR_MINUS;
        item.last = 1'b0;
        pending_chars.push_back(item);
      end
      for (int k = cnt - 1; k >= 0; k--) begin
        item.ch   = glyph(digit_lane[k]);
        item.last = (k == 0);
        pending_chars.push_back(item);
      end
      return cnt + int'(was_negative);
    endfunction

    function void check_char(logic [CHAR_W-1:0] ch, logic lst);
      out_item_t want;
      if (pending_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected character %h last %b at %0t", ch, lst, $time);
        return;
      end
      want = pending_chars.pop_front();
      if (ch !== want.ch || lst !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("character mismatch at %0t: expected %h last %b, got %h last %b",
                   $time, want.ch, want.last, ch, lst);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic [NUMBER_W-1:0] number = '0;
  logic                full;
  logic                empty;
  logic                pop = 1'b0;
  logic [CHAR_W-1:0]   out_char;
  logic                last;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  cfg_reg_t            cfg_index = REG_RADIX;
  logic [ALPHA_W-1:0]  cfg_data = '0;

  radix_text_scoreboard board = new();

  int gap_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int converted_numbers = 0;
  int cycle_count = 0;

  signed_integer_to_radix_text dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .number    (number),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .out_char  (out_char),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Pop characters, with random stalls and an occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) board.check_char(out_char, last);
      if (hold_requests != holds_served) begin
        holds_served <= holds_served + 1;
        hold_left <= LONG_HOLD;
        pop <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Leave cfg_valid high; the caller drops it after the last write
  task automatic write_reg(cfg_reg_t idx, logic [ALPHA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.note_write(idx, data);
  endtask

  task automatic load_alphabet(logic [RADIX_W-1:0] r, logic [ALPHA_W-1:0] lo,
                               logic [ALPHA_W-1:0] hi);
    logic [ALPHA_W-1:0] radix_word;
    // Fill the unused upper bits with noise
    radix_word = {$urandom(), $urandom()};
    radix_word[RADIX_W-1:0] = r;
    write_reg(REG_RADIX, radix_word);
    write_reg(REG_ALPHA_LOW, lo);
    write_reg(REG_ALPHA_HIGH, hi);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_number(logic [NUMBER_W-1:0] n);
    while ($urandom_range(0, 99) < gap_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push   <= 1'b1;
    number <= n;
    @(posedge clk);
    while (full) @(posedge clk);
    if (board.note_number(n) > 0) converted_numbers++;
  endtask

  // Drain all characters, then let any silent numbers clear the block
  task automatic settle();
    push <= 1'b0;
    while (board.pending_chars.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin gap_pct <= 0;  stall_pct <= 0;  end
      1: begin gap_pct <= 70; stall_pct <= 0;  end
      2: begin gap_pct <= 0;  stall_pct <= 70; end
      default: begin gap_pct <= 27; stall_pct <= 27; end
    endcase
  endtask

  function automatic logic [NUMBER_W-1:0] pick_number();
    logic [NUMBER_W-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = '0;
          default: v = '1;
        endcase
      end
      1, 2: begin
        v = 32'($urandom_range(0, 40));
        if ($urandom_range(0, 1)) v = -v;
      end
      3, 4, 5: begin
        v = $urandom() >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // Build a random alphabet, broken in one way unless usable is set
  function automatic void make_alphabet(input bit usable, output logic [RADIX_W-1:0] r,
                                        output logic [ALPHA_W-1:0] lo,
                                        output logic [ALPHA_W-1:0] hi);
    logic [2*ALPHA_W-1:0] tbl;
    bit   [255:0]         taken;
    logic [CHAR_W-1:0]    c;
    int                   i;
    int                   j;
    taken = '0;
    r = 5'($urandom_range(2, MAX_RADIX_DEF));
    for (int d = 0; d < 16; d++) begin
      if (d < r) begin
        do c = 8'($urandom_range(0, 255));
        while (taken[c] || c == CHAR_PLUS || c == CHAR_MINUS);
        taken[c] = 1'b1;
      end else begin
        c = 8'($urandom_range(0, 255));
      end
      tbl[d*8 +: 8] = c;
    end
    if (!usable) begin
      i = $urandom_range(0, r - 1);
      case ($urandom_range(0, 4))
        0: r = 5'($urandom_range(0, 1));
        1: r = 5'($urandom_range(MAX_RADIX_DEF + 1, 31));
        2: tbl[i*8 +: 8] = CHAR_PLUS;
        3: tbl[i*8 +: 8] = CHAR_MINUS;
        default: begin
          j = (i + 1 + $urandom_range(0, r - 2)) % r;
          tbl[j*8 +: 8] = tbl[i*8 +: 8];
        end
      endcase
    end
    lo = tbl[ALPHA_W-1:0];
    hi = tbl[2*ALPHA_W-1:ALPHA_W];
  endfunction

  initial begin
    logic [RADIX_W-1:0] r;
    logic [ALPHA_W-1:0] lo;
    logic [ALPHA_W-1:0] hi;
    bit                 usable;
    int                 phase;
    int                 count;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty alphabet: no characters
    load_alphabet(5'd0, '0, '0);
    send_number(32'd12345);
    settle();

    // Single-character alphabet
    load_alphabet(5'd1, "76543210", "++++++98");
    send_number(-32'sd5);
    settle();

    // Radix above the maximum
    load_alphabet(5'd17, "76543210", "FEDCBA98");
    send_number(32'd100);
    settle();

    // Largest radix code with all-ones alphabet
    load_alphabet(5'd31, '1, '1);
    send_number(32'd7);
    settle();

    // Plus sign inside the alphabet
    load_alphabet(5'd10, "765+3210", "++++++98");
    send_number(32'd42);
    settle();

    // Minus sign as the top hex digit
    load_alphabet(5'd16, "76543210", "-EDCBA98");
    send_number(32'd42);
    settle();

    // Repeated character
    load_alphabet(5'd10, "76543210", "++++++08");
    send_number(32'd42);
    settle();

    // Decimal extremes; unused upper slots hold plus signs
    load_alphabet(5'd10, "76543210", "++++++98");
    send_number(32'd0);
    send_number(32'd1);
    send_number(-32'sd1);
    send_number(32'd9);
    send_number(32'd10);
    send_number(-32'sd10);
    send_number(32'h7FFF_FFFF);
    send_number(32'h8000_0000);
    settle();

    // Binary: most negative value gives the longest text
    load_alphabet(5'd2, "76543210", '0);
    send_number(32'h8000_0000);
    send_number(32'h7FFF_FFFF);
    send_number(32'd0);
    settle();

    // Full hex alphabet
    load_alphabet(5'd16, "76543210", "FEDCBA98");
    send_number(32'hFFFF_FFFF);
    send_number(32'h7FFF_FFFF);
    send_number(32'h8000_0000);
    send_number(32'hDEAD_BEEF);
    settle();

    // Zero byte used as a digit
    load_alphabet(5'd3, 64'h0000_0000_0062_6100, '0);
    send_number(32'd0);
    send_number(32'd5);
    send_number(-32'sd7);
    settle();

    // Random alphabets and numbers, cycling through idling modes
    converted_numbers = 0;
    phase = 0;
    while (converted_numbers < TARGET_ITEMS) begin
      usable = (phase == 2) || ($urandom_range(0, 99) >= 15);
      make_alphabet(usable, r, lo, hi);
      load_alphabet(r, lo, hi);
      if (phase == 2) begin
        // Hold off the receiver while the sender keeps pushing
        set_idling(0);
        hold_requests <= hold_requests + 1;
      end else begin
        set_idling(phase % 4);
      end
      count = usable ? $urandom_range(12, 36) : 3;
      repeat (count) send_number(pick_number());
      settle();
      phase++;
    end

    if (board.mismatches == 0 && board.pending_chars.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
